// ----- sv/int16_to_float_dequantizer_top_defines.svh -----
// Assertion macros for the int16 to float dequantizer checker
`ifndef INT16_TO_FLOAT_DEQUANTIZER_TOP_DEFINES_SVH
`define INT16_TO_FLOAT_DEQUANTIZER_TOP_DEFINES_SVH
// check outside reset
`define DQ_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("dequantizer check failed");
// check at every edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clock) prop) \
   else $error("dequantizer check failed");
`endif

// ----- sv/i2fdq_pkg.sv -----
// Constants and types shared by the int16 to float dequantizer files
package i2fdq_pkg;
   localparam logic [31:0] SCALE_RESET = 32'h4A80_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF     = 32'h7F80_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam int          PROD_W      = 40;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              sign;
      logic              special;
      logic [31:0]       special_bits;
      logic [7:0]        eff_exp;
      logic [PROD_W-1:0] prod;
   } prod_stage_type;
endpackage

// ----- sv/int16_to_float_dequantizer_top.sv -----
// Top level: int16 sample times fp32 multiplier, rounded to fp32
//  channel | ports                                     | direction
//  request | start, busy, req_sample, req_last_in      | in (busy out)
//  result  | rsp_valid, rsp_value_bits, rsp_last_out   | out
//  config  | csr_valid, csr_ready, csr_data            | in (csr_ready out)
// One beat per cycle while busy is low; a result passes from its start beat
// through the input register, product register and result register.
// Reset is synchronous; busy is high and csr_ready low only while reset is high.
// The receiver cannot stall: every result is shown for one cycle.
module int16_to_float_dequantizer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_sample,
   input  logic               req_last_in,
   output logic               rsp_valid,
   output logic [31:0]        rsp_value_bits,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);
   logic [31:0]                  scale_ff, scale_in;
   logic                         in_valid_ff, in_valid_in;
   logic                         in_last_ff;
   logic [15:0]                  in_sample_ff;
   i2fdq_pkg::prod_stage_type    prod_ff, prod_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_last_ff;
   logic [31:0]                  out_bits_ff, out_bits_in;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign scale_in  = (csr_valid && csr_ready) ? csr_data : scale_ff;
   assign in_valid_in = start && !busy;

   // product stage
   logic        sm, sx;
   logic [7:0]  em;
   logic [22:0] fm;
   logic [16:0] mag;
   logic [23:0] sig;
   always_comb begin
      sm  = scale_ff[31];
      em  = scale_ff[30:23];
      fm  = scale_ff[22:0];
      sx  = in_sample_ff[15];
      mag = sx ? (17'h1_0000 - {1'b0, in_sample_ff}) : {1'b0, in_sample_ff};
      sig = (em != 8'd0) ? {1'b1, fm} : {1'b0, fm};
      prod_in.valid        = in_valid_ff;
      prod_in.last         = in_last_ff;
      prod_in.sign         = sm ^ sx;
      prod_in.eff_exp      = (em != 8'd0) ? em : 8'd1;
      prod_in.prod         = 40'(sig) * 40'(mag);
      prod_in.special      = 1'b0;
      prod_in.special_bits = {sm ^ sx, 31'd0};
      if (em == 8'hFF) begin
         prod_in.special = 1'b1;
         if (fm != 23'd0) begin
            prod_in.special_bits = scale_ff | i2fdq_pkg::QUIET_BIT;
         end else if (mag == 17'd0) begin
            prod_in.special_bits = i2fdq_pkg::DEFAULT_NAN;
         end else begin
            prod_in.special_bits = {sm ^ sx, i2fdq_pkg::POS_INF[30:0]};
         end
      end else if (mag == 17'd0 || (em == 8'd0 && fm == 23'd0)) begin
         prod_in.special = 1'b1;
      end
   end

   // normalise and round stage
   logic [5:0]  lead;
   logic [8:0]  exp_sum;
   logic        norm;
   logic signed [9:0] sh;
   logic [4:0]  lsh, rsh;
   logic [39:0] q, mask, rem, half;
   logic [32:0] packed_bits;
   always_comb begin
      lead = 6'd0;
      for (int i = 0; i < i2fdq_pkg::PROD_W; i++) begin
         if (prod_ff.prod[i]) begin
            lead = 6'(i);
         end
      end
      exp_sum = 9'(lead) + 9'(prod_ff.eff_exp);
      norm    = exp_sum >= 9'd46;
      sh      = norm ? (10'(lead) - 10'sd23) : (10'sd23 - 10'(prod_ff.eff_exp));
      lsh     = 5'(-sh);
      rsh     = sh[4:0];
      mask    = (40'd1 << rsh) - 40'd1;
      half    = 40'd1 << (rsh - 5'd1);
      rem     = prod_ff.prod & mask;
      if (sh <= 10'sd0) begin
         q = prod_ff.prod << lsh;
      end else begin
         q = prod_ff.prod >> rsh;
         if (rem > half || (rem == half && q[0])) begin
            q = q + 40'd1;
         end
      end
      packed_bits = ({24'd0, exp_sum - 9'd46} << 23) + q[32:0];
      if (prod_ff.special) begin
         out_bits_in = prod_ff.special_bits;
      end else if (norm) begin
         if (packed_bits >= {1'b0, i2fdq_pkg::POS_INF}) begin
            out_bits_in = {prod_ff.sign, i2fdq_pkg::POS_INF[30:0]};
         end else begin
            out_bits_in = {prod_ff.sign, packed_bits[30:0]};
         end
      end else begin
         out_bits_in = {prod_ff.sign, q[30:0]};
      end
      out_valid_in = prod_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= i2fdq_pkg::SCALE_RESET;
         in_valid_ff   <= 1'b0;
         prod_ff.valid <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         scale_ff      <= scale_in;
         in_valid_ff   <= in_valid_in;
         prod_ff.valid <= prod_in.valid;
         out_valid_ff  <= out_valid_in;
      end
      in_sample_ff         <= req_sample;
      in_last_ff           <= req_last_in;
      prod_ff.last         <= prod_in.last;
      prod_ff.sign         <= prod_in.sign;
      prod_ff.special      <= prod_in.special;
      prod_ff.special_bits <= prod_in.special_bits;
      prod_ff.eff_exp      <= prod_in.eff_exp;
      prod_ff.prod         <= prod_in.prod;
      out_last_ff          <= prod_ff.last;
      out_bits_ff          <= out_bits_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value_bits = out_bits_ff;
   assign rsp_last_out   = out_last_ff;
endmodule

// ----- sv/i2fdq_checker.sv -----
// Port checker for the int16 to float dequantizer, bound to the top level
`include "int16_to_float_dequantizer_top_defines.svh"
module i2fdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_value_bits,
   input logic        csr_ready
);
   `DQ_ASSERT_ALWAYS(a_busy_only_in_reset, busy == reset && csr_ready == !reset)
   `DQ_ASSERT(a_start_gives_beat, start && !busy |-> ##3 rsp_valid)
   `DQ_ASSERT(a_beat_has_start, rsp_valid |-> $past(start, 3))
   `DQ_ASSERT(a_nan_is_quiet, rsp_valid && rsp_value_bits[30:23] == 8'hFF && rsp_value_bits[22:0] != 23'd0 |-> rsp_value_bits[22])
   `DQ_ASSERT(a_inf_mask, rsp_valid |-> rsp_value_bits[30:0] <= i2fdq_pkg::POS_INF[30:0] || rsp_value_bits[22])
endmodule

bind int16_to_float_dequantizer_top i2fdq_checker u_i2fdq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_value_bits (rsp_value_bits),
   .csr_ready      (csr_ready)
);
